>>> rtl/bvs_pkg.sv
// shared types, widths and codes for the bounded vector store
`default_nettype none
package bvs_pkg;
	localparam int DEPTH  = 1024;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 11;
	localparam int WORD_W = 32;
	localparam int ST_W   = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [WORD_W-1:0] read_value;
		logic [POS_W-1:0]         found_position;
	} res_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;
endpackage
`default_nettype wire

>>> rtl/bvs_if.sv
// command and result channel interfaces
`default_nettype none
interface bvs_cmd_if;
	import bvs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [WORD_W-1:0] data_value;
	modport source (output valid, command, position, data_value, input ready);
	modport sink (input valid, command, position, data_value, output ready);
endinterface

interface bvs_res_if;
	import bvs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic signed [WORD_W-1:0] read_value;
	logic [POS_W-1:0]         found_position;
	modport source (output valid, status, read_value, found_position, input ready);
	modport sink (input valid, status, read_value, found_position, output ready);
endinterface
`default_nettype wire

>>> rtl/bvs_mem.sv
// element store: one write port, one registered read port
`default_nettype none
module bvs_mem (
	input  wire logic               clk,
	input  wire bvs_pkg::mem_req_t  mreq,
	output logic [bvs_pkg::WORD_W-1:0] rdata
);
	import bvs_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[mreq.wr_addr] <= mreq.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rdata <= mem_q[mreq.rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/bvs_ctrl.sv
// command sequencer with element count and shared compare for find
`default_nettype none
module bvs_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bvs_cmd_if.sink                    req,
	output bvs_pkg::mem_req_t          mreq,
	input  wire logic [bvs_pkg::WORD_W-1:0] rdata,
	output bvs_pkg::res_t              res,
	output logic                       res_valid,
	input  wire logic                  res_ready
);
	import bvs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_FIND = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [WORD_W-1:0] data_q, data_d;
	res_t              res_q, res_d;
	logic [CMP_W-1:0]  pos_ext;
	logic              pos_ok;
	logic              full;

	assign req.ready = (state_q == S_IDLE);
	assign res       = res_q;
	assign res_valid = (state_q == S_DONE);

	assign pos_ext = CMP_W'(req.position);
	assign pos_ok  = (req.position != '0) && (pos_ext <= CMP_W'(cnt_q));
	assign full    = (cnt_q == CNT_W'(DEPTH));

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		data_d  = data_q;
		res_d   = res_q;
		mreq    = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					res_d   = '0;
					data_d  = req.data_value;
					state_d = S_DONE;
					case (req.command)
						CMD_PUSH: begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								mreq.wr_en   = 1'b1;
								mreq.wr_addr = ADDR_W'(cnt_q);
								mreq.wr_data = req.data_value;
								cnt_d        = cnt_q + CNT_W'(1);
							end
						end
						CMD_POP: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								cnt_d        = cnt_q - CNT_W'(1);
								mreq.rd_en   = 1'b1;
								mreq.rd_addr = ADDR_W'(cnt_q - CNT_W'(1));
								state_d      = S_RD;
							end
						end
						CMD_SET: begin
							if (pos_ok) begin
								mreq.wr_en   = 1'b1;
								mreq.wr_addr = ADDR_W'(pos_ext - CMP_W'(1));
								mreq.wr_data = req.data_value;
							end else begin
								res_d.status = ST_RANGE;
							end
						end
						CMD_GET: begin
							if (pos_ok) begin
								mreq.rd_en   = 1'b1;
								mreq.rd_addr = ADDR_W'(pos_ext - CMP_W'(1));
								state_d      = S_RD;
							end else begin
								res_d.status = ST_RANGE;
							end
						end
						CMD_FIND: begin
							if (cnt_q != '0) begin
								idx_d        = '0;
								mreq.rd_en   = 1'b1;
								mreq.rd_addr = '0;
								state_d      = S_FIND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RD: begin
				res_d.read_value = rdata;
				state_d          = S_DONE;
			end
			S_FIND: begin
				if (rdata == data_q) begin
					res_d.found_position = POS_W'(CNT_W'(idx_q) + CNT_W'(1));
					state_d              = S_DONE;
				end else if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
					state_d = S_DONE;
				end else begin
					idx_d        = idx_q + ADDR_W'(1);
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = idx_q + ADDR_W'(1);
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		data_q <= data_d;
		res_q  <= res_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_find_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIND |-> CNT_W'(idx_q) < cnt_q)
		else $error("find index past element count");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.command == CMD_PUSH && !full)
		|=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("push did not grow the count");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.wr_en |-> CNT_W'(mreq.wr_addr) <= cnt_q)
		else $error("write beyond the tail");
endmodule
`default_nettype wire

>>> rtl/bounded_vector_store_top.sv
// bounded vector store: top level with result output register
//
// usage: commands arrive on req (valid/ready), one result per item leaves on rsp.
// push, pop, set and get touch the element store at most once; find walks it from
// position 1 upward through the single read port, one element a cycle, and
// compares each word with the search value in one shared comparator.
// on the way to rsp.valid, each item's result is registered in the sequencer
// and then in the output register; pop and get add a registered memory read
// before that, and find adds one compare per element scanned (0..count).
// req.ready is high only while the sequencer is idle, so the block takes no
// new item until the sequencer is through with the last one; the store's
// read port sets the find rate.
// the result sits in an output register, so a new item is taken while the
// previous result waits for rsp.ready; if the receiver stalls longer, the
// next finished result holds in the sequencer and req.ready stays low.
// reset: arst_n clears the element count and the control state at once;
// the store contents are not cleared; an item in flight is lost, none is invented.
`default_nettype none
module bounded_vector_store_top (
	input  wire logic clk,
	input  wire logic arst_n,
	bvs_cmd_if.sink   req,
	bvs_res_if.source rsp
);
	import bvs_pkg::*;

	mem_req_t          mreq;
	logic [WORD_W-1:0] rdata;
	res_t              res;
	logic              res_valid;
	logic              res_ready;
	logic              out_valid_q;
	res_t              out_q;

	bvs_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	bvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mreq      (mreq),
		.rdata     (rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.read_value     = out_q.read_value;
	assign rsp.found_position = out_q.found_position;
endmodule
`default_nettype wire
